// ----- src/clcd_pkg.sv -----
// Shared definitions for the console line command decoder.
// Holds the command codes, the result record, character constants and keyword tables.
// Used by clcd_scan and console_line_command_decoder; depends on nothing.
package clcd_pkg;

    localparam int LINE_DEPTH = 32;

    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CASE_BIT = 8'h20;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;

    localparam int SET_LEN     = 3;
    localparam int RESET_LEN   = 5;
    localparam int THREADS_LEN = 7;

    typedef enum logic [1:0] {
        CMD_SET     = 2'd0,
        CMD_RESET   = 2'd1,
        CMD_THREADS = 2'd2,
        CMD_UNKNOWN = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd        code;
        logic [31:0] value;
    } t_result;

    typedef struct packed {
        logic start;
        logic beat;
    } t_scan_ctl;

    function automatic logic [7:0] set_char(input logic [2:0] k);
        logic [7:0] c;
        case (k)
            3'd0:    c = 8'h73;
            3'd1:    c = 8'h65;
            3'd2:    c = 8'h74;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] reset_char(input logic [2:0] k);
        logic [7:0] c;
        case (k)
            3'd0:    c = 8'h72;
            3'd1:    c = 8'h65;
            3'd2:    c = 8'h73;
            3'd3:    c = 8'h65;
            3'd4:    c = 8'h74;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] threads_char(input logic [2:0] k);
        logic [7:0] c;
        case (k)
            3'd0:    c = 8'h74;
            3'd1:    c = 8'h68;
            3'd2:    c = 8'h72;
            3'd3:    c = 8'h65;
            3'd4:    c = 8'h61;
            3'd5:    c = 8'h64;
            3'd6:    c = 8'h73;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ----- src/clcd_scan.sv -----
// Line scanner: consumes the stored line one byte per beat and forms the result.
// Tracks keyword matches and accumulates the decimal value after the set keyword.
// Depends on clcd_pkg.
module clcd_scan #(
    parameter int LINE_DEPTH = clcd_pkg::LINE_DEPTH,
    localparam int LW = $clog2(LINE_DEPTH + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  clcd_pkg::t_scan_ctl i_ctl,
    input  logic [LW-1:0]       i_pos,
    input  logic [7:0]          i_data,
    input  logic [LW-1:0]       i_len,
    output clcd_pkg::t_result   o_result
);

    logic        r_set_ok;
    logic        r_rst_ok;
    logic        r_thr_ok;
    logic        r_dig_on;
    logic [31:0] r_value;
    logic        n_set_ok;
    logic        n_rst_ok;
    logic        n_thr_ok;
    logic        n_dig_on;
    logic [31:0] n_value;
    logic        is_digit;

    assign is_digit = (i_data >= clcd_pkg::CH_0) && (i_data <= clcd_pkg::CH_9);

    always_comb begin
        n_set_ok = r_set_ok;
        n_rst_ok = r_rst_ok;
        n_thr_ok = r_thr_ok;
        n_dig_on = r_dig_on;
        n_value  = r_value;
        if (i_ctl.start) begin
            n_set_ok = 1'b1;
            n_rst_ok = 1'b1;
            n_thr_ok = 1'b1;
            n_dig_on = 1'b1;
            n_value  = '0;
        end else if (i_ctl.beat) begin
            if (i_pos < LW'(clcd_pkg::SET_LEN)) begin
                if (i_data != clcd_pkg::set_char(i_pos[2:0])) begin
                    n_set_ok = 1'b0;
                end
            end else if (r_dig_on) begin
                if (is_digit) begin
                    n_value = (r_value << 3) + (r_value << 1) + 32'(i_data[3:0]);
                end else begin
                    n_dig_on = 1'b0;
                end
            end
            if (i_pos < LW'(clcd_pkg::RESET_LEN)) begin
                if (i_data != clcd_pkg::reset_char(i_pos[2:0])) begin
                    n_rst_ok = 1'b0;
                end
            end
            if (i_pos < LW'(clcd_pkg::THREADS_LEN)) begin
                if (i_data != clcd_pkg::threads_char(i_pos[2:0])) begin
                    n_thr_ok = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_ok <= 1'b0;
            r_rst_ok <= 1'b0;
            r_thr_ok <= 1'b0;
            r_dig_on <= 1'b0;
            r_value  <= '0;
        end else begin
            r_set_ok <= n_set_ok;
            r_rst_ok <= n_rst_ok;
            r_thr_ok <= n_thr_ok;
            r_dig_on <= n_dig_on;
            r_value  <= n_value;
        end
    end

    always_comb begin
        o_result.value = '0;
        if ((i_len >= LW'(clcd_pkg::SET_LEN)) && r_set_ok) begin
            o_result.code  = clcd_pkg::CMD_SET;
            o_result.value = r_value;
        end else if ((i_len == LW'(clcd_pkg::RESET_LEN)) && r_rst_ok) begin
            o_result.code = clcd_pkg::CMD_RESET;
        end else if ((i_len == LW'(clcd_pkg::THREADS_LEN)) && r_thr_ok) begin
            o_result.code = clcd_pkg::CMD_THREADS;
        end else begin
            o_result.code = clcd_pkg::CMD_UNKNOWN;
        end
    end

endmodule

// ----- src/console_line_command_decoder.sv -----
// Top level of the console line command decoder: line memory, control and result register.
// Instantiates clcd_scan; depends on clcd_pkg.
//
// Channel | Direction | Handshake             | Payload
// in      | receive   | i_in_valid/o_in_stall | i_rx_done, i_rx_byte
// out     | send      | o_out_valid/i_out_stall | o_command_code, o_set_value
//
// A character beat writes one line memory entry.
// A carriage return walks the stored line through the single read port, one entry per
// cycle, into the scanner, and the scanner's result is then registered as the output.
// Input is stalled during that walk, and longer while an earlier result still waits; a
// finished result may wait for the consumer while new characters are taken.
// Reset is synchronous and needs no memory clearing pass.
module console_line_command_decoder #(
    parameter int LINE_DEPTH = clcd_pkg::LINE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_rx_done,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_command_code,
    output logic [31:0] o_set_value
);

    localparam int IW = $clog2(LINE_DEPTH);
    localparam int LW = $clog2(LINE_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    t_state              r_state;
    logic [IW-1:0]       r_wp;
    logic [LW-1:0]       r_len;
    logic [LW-1:0]       r_scan_idx;
    logic                r_rd_vld;
    logic [LW-1:0]       r_rd_pos;
    logic [7:0]          r_rd_data;
    logic                r_out_valid;
    logic [1:0]          r_code;
    logic [31:0]         r_value;
    logic [7:0]          r_mem [LINE_DEPTH];

    logic                in_beat;
    logic                wr_en;
    logic                cr_beat;
    clcd_pkg::t_scan_ctl scan_ctl;
    clcd_pkg::t_result   scan_res;

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_beat     = i_in_valid && !o_in_stall && i_rx_done;
    assign cr_beat     = in_beat && (i_rx_byte == clcd_pkg::CH_CR);
    assign wr_en       = in_beat && (i_rx_byte != clcd_pkg::CH_CR);

    assign scan_ctl.start = cr_beat;
    assign scan_ctl.beat  = r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wp] <= i_rx_byte | clcd_pkg::CASE_BIT;
        end
        r_rd_data <= r_mem[r_scan_idx[IW-1:0]];
    end

    clcd_scan #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (scan_ctl),
        .i_pos    (r_rd_pos),
        .i_data   (r_rd_data),
        .i_len    (r_len),
        .o_result (scan_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wp        <= '0;
            r_len       <= '0;
            r_scan_idx  <= '0;
            r_rd_vld    <= 1'b0;
            r_rd_pos    <= '0;
            r_out_valid <= 1'b0;
            r_code      <= '0;
            r_value     <= '0;
        end else begin
            if (r_out_valid && !i_out_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (wr_en) begin
                        r_len <= LW'(r_wp) + LW'(1);
                        if (r_wp != IW'(LINE_DEPTH - 1)) begin
                            r_wp <= r_wp + IW'(1);
                        end
                    end else if (cr_beat) begin
                        r_wp       <= '0;
                        r_scan_idx <= '0;
                        r_state    <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_scan_idx < r_len) begin
                        r_rd_vld   <= 1'b1;
                        r_rd_pos   <= r_scan_idx;
                        r_scan_idx <= r_scan_idx + LW'(1);
                    end else begin
                        r_rd_vld <= 1'b0;
                        if (!r_rd_vld) begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_code      <= scan_res.code;
                        r_value     <= scan_res.value;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_command_code = r_code;
    assign o_set_value    = r_value;

`ifndef SYNTHESIS
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LW'(LINE_DEPTH))
        else $error("Line length exceeds the line memory depth.");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_scan_idx <= r_len))
        else $error("Scan index ran past the line length.");

    a_no_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !wr_en)
        else $error("Line memory written while a line is being decoded.");

    a_value_only_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_command_code != clcd_pkg::CMD_SET)) |-> (o_set_value == 32'd0))
        else $error("Nonzero value on a result other than set.");

    a_rd_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> (r_state == S_SCAN))
        else $error("Read data beat outside the scan.");
`endif

endmodule
